// ===== rtl/dq_pkg.sv =====
// Package for the double-ended queue: sizes, operation and status codes,
// and the control bundle that the top level sends to each storage cell.
// No dependencies.
package dq_pkg;

  localparam int DEPTH  = 16;
  localparam int WORD_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OP_W   = 3;
  localparam int LEN_W  = 5;
  localparam int STAT_W = 2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK       = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Per-cell control for one cycle.
  typedef struct packed {
    logic take_prev;  // shift toward the back (push at the front)
    logic take_next;  // shift toward the front (pop at the front)
    logic load;       // write the pushed word here (push at the back)
    logic is_front;   // this cell holds the front word after the step
    logic is_back;    // this cell holds the back word after the step
  } cell_ctl_t;

endpackage

// ===== rtl/dq_cell.sv =====
// One storage cell of the deque's shift chain: a word register that can
// take its neighbor's word or the pushed word, plus gated result taps.
// Depends on dq_pkg.
module dq_cell
  import dq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  word_t     push_word,
  input  word_t     prev_word,
  input  word_t     next_word,
  output word_t     word,
  output word_t     front_tap,
  output word_t     back_tap
);

  word_t word_r;
  word_t word_nxt;

  always_comb begin
    if (ctl.take_prev) begin
      word_nxt = prev_word;
    end else if (ctl.take_next) begin
      word_nxt = next_word;
    end else if (ctl.load) begin
      word_nxt = push_word;
    end else begin
      word_nxt = word_r;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  // Taps are zero unless this cell is the selected end, so the top level
  // can merge all cells with a plain OR.
  assign word      = word_r;
  assign front_tap = ctl.is_front ? word_nxt : '0;
  assign back_tap  = ctl.is_back  ? word_nxt : '0;

endmodule

// ===== rtl/double_ended_queue_core.sv =====
// Top level of the double-ended queue: control, count register, chain of
// storage cells and the result register.
// Depends on dq_pkg and dq_cell.
//
//   Channel  Ports                                  Direction  Moves
//   in       in_valid/in_ready, in_op, in_data_value  input      one request item
//   out      out_valid/out_ready, out_front_value,    output     one result item
//            out_back_value, out_length, out_status
//
// The block takes one item per cycle. Each item is worked out in the cycle
// it is accepted and its result lands in the output register at that edge.
// in_ready is high whenever the output register is empty or is being
// drained in the same cycle, so a stall on the result side stalls input.
// Reset clears the count and the result valid flag; cell words need none,
// since only occupied cells are ever shown.
module double_ended_queue_core
  import dq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_op,
  input  word_t              in_data_value,
  output logic               out_valid,
  input  logic               out_ready,
  output word_t              out_front_value,
  output word_t              out_back_value,
  output logic [LEN_W-1:0]   out_length,
  output logic [STAT_W-1:0]  out_status
);

  // The queue is kept in a row of cells with the front word always in cell
  // zero. A front push shifts every cell one place toward the back, a front
  // pop shifts one place toward the front, a back push writes the cell just
  // past the last occupied one, and a back pop only lowers the count.

  logic    accept;
  logic    full;
  logic    empty;
  logic    do_push_front;
  logic    do_push_back;
  logic    do_pop_front;
  status_t status;
  cnt_t    count_r;
  cnt_t    count_nxt;

  logic             out_valid_r;
  word_t            front_r;
  word_t            back_r;
  logic [LEN_W-1:0] length_r;
  status_t          status_r;

  cell_ctl_t ctl       [DEPTH];
  word_t     cell_word [DEPTH];
  word_t     front_tap [DEPTH];
  word_t     back_tap  [DEPTH];
  word_t     front_value;
  word_t     back_value;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);

  // Decode the request. Refused requests and unused codes leave the state
  // alone; unused codes act as a peek, refused ones report ST_FULL or ST_EMPTY.
  always_comb begin
    do_push_front = 1'b0;
    do_push_back  = 1'b0;
    do_pop_front  = 1'b0;
    status        = ST_DONE;
    count_nxt     = count_r;
    case (in_op)
      OP_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          do_push_front = 1'b1;
          count_nxt     = count_r + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          do_push_back = 1'b1;
          count_nxt    = count_r + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          do_pop_front = 1'b1;
          count_nxt    = count_r - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  // Per-cell control. The end flags refer to the occupancy after the step,
  // so an emptied queue selects no cell and both ends read zero.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].take_prev = accept && do_push_front;
      ctl[i].take_next = accept && do_pop_front;
      ctl[i].load      = accept && do_push_back && (count_r == CNT_W'(i));
      ctl[i].is_front  = (i == 0) && (count_nxt != '0);
      ctl[i].is_back   = (count_nxt == CNT_W'(i + 1));
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    word_t prev_word;
    word_t next_word;

    // The first cell takes the pushed word on a front push; the last cell
    // keeps its own word on a front pop, where it falls out of range anyway.
    if (g == 0) begin : g_first
      assign prev_word = in_data_value;
    end else begin : g_mid_prev
      assign prev_word = cell_word[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_word = cell_word[g];
    end else begin : g_mid_next
      assign next_word = cell_word[g+1];
    end

    dq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[g]),
      .push_word (in_data_value),
      .prev_word (prev_word),
      .next_word (next_word),
      .word      (cell_word[g]),
      .front_tap (front_tap[g]),
      .back_tap  (back_tap[g])
    );
  end

  // At most one cell drives each tap, so the ends merge by OR.
  always_comb begin
    front_value = '0;
    back_value  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      front_value = front_value | front_tap[i];
      back_value  = back_value  | back_tap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted item.
  always_ff @(posedge clk) begin
    if (accept) begin
      front_r  <= front_value;
      back_r   <= back_value;
      length_r <= LEN_W'(count_nxt);
      status_r <= status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_front_value = front_r;
  assign out_back_value  = back_r;
  assign out_length      = length_r;
  assign out_status      = status_r;

endmodule
